// ===== design/ildp_pkg.sv =====
// Shared types, constants and lookup functions for the ISO 8211 leader and directory parser.
`default_nettype none

package ildp_pkg;

  // Largest digit count accepted for the length and position size fields.
  localparam int unsigned MAX_DIGITS = 9;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_USER_W = 2;

  // Record framing constants.
  localparam logic [7:0]  FIELD_END  = 8'h1E;
  localparam int unsigned LEADER_LEN = 24;
  localparam int unsigned DIR_BASE   = LEADER_LEN + 1;
  localparam int unsigned TAG_BYTES  = 4;

  // Entry sizes that can occur, one remainder lane per size.
  localparam int unsigned MOD_LO    = TAG_BYTES + 2;
  localparam int unsigned MOD_HI    = TAG_BYTES + 2 * MAX_DIGITS;
  localparam int unsigned MOD_LANES = MOD_HI - MOD_LO + 1;
  localparam int unsigned MOD_IW    = $clog2(MOD_LANES);

  // Queue between the classifier and the parser.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [3:0] ERR_STAMP      = 4'd0;
  localparam logic [3:0] ERR_INDICATOR  = 4'd1;
  localparam logic [3:0] ERR_LEN_SIZE   = 4'd2;
  localparam logic [3:0] ERR_POS_SIZE   = 4'd3;
  localparam logic [3:0] ERR_RESERVED   = 4'd4;
  localparam logic [3:0] ERR_TAG_SIZE   = 4'd5;
  localparam logic [3:0] ERR_DIGIT      = 4'd6;
  localparam logic [3:0] ERR_DIR_SIZE   = 4'd7;
  localparam logic [3:0] ERR_TERMINATOR = 4'd8;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       descriptive_record;
    logic       is_digit;
    logic [3:0] digit;
  } ildp_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] entry_tag;
    logic [29:0] entry_length;
    logic [29:0] entry_position;
    logic [3:0]  error_code;
    logic [7:0]  payload_byte;
    logic        record_end;
  } ildp_result_t;

  // Queue occupancy as seen by the classifier and the top level.
  typedef struct packed {
    logic [QUEUE_LW-1:0] level;
    logic                full;
    logic                empty;
  } ildp_qstat_t;

  // Expected stamp byte for the given position within the stamp.
  function automatic logic [7:0] stamp_byte(input logic descriptive, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h20;
    if (descriptive) begin
      case (idx)
        3'd0: b = 8'h33;   // '3'
        3'd1: b = 8'h4C;   // 'L'
        3'd2: b = 8'h45;   // 'E'
        3'd3: b = 8'h31;   // '1'
        3'd4: b = 8'h20;   // ' '
        3'd5: b = 8'h30;   // '0'
        3'd6: b = 8'h39;   // '9'
        default: b = 8'h20;
      endcase
    end else begin
      case (idx)
        3'd1: b = 8'h44;   // 'D'
        default: b = 8'h20;
      endcase
    end
    return b;
  endfunction

  // Expected indicator byte for the given position within the indicator.
  function automatic logic [7:0] indicator_byte(input logic descriptive, input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h20;
    case (idx)
      2'd1: b = descriptive ? 8'h21 : 8'h20;   // '!' for descriptive records
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/ildp_front.sv =====
// Input side: takes stream bytes, classifies them and pushes them into the queue.
`default_nettype none

module ildp_front (
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ildp_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [ildp_pkg::IN_USER_W-1:0]      in_tuser,
  input  wire ildp_pkg::ildp_qstat_t               qstat,
  output logic                                     push,
  output ildp_pkg::ildp_item_t                     push_item
);
  import ildp_pkg::*;

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && !qstat.full;

  // Decimal digit detection is done here so the parser only sees a flag and a value.
  always_comb begin
    push_item.data_byte          = in_tdata;
    push_item.record_start       = in_tuser[0];
    push_item.descriptive_record = in_tuser[1];
    push_item.is_digit           = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
    push_item.digit              = 4'(in_tdata - 8'h30);
  end

endmodule

`default_nettype wire

// ===== design/ildp_fifo.sv =====
// Short queue of classified bytes between the classifier and the parser.
`default_nettype none

module ildp_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ildp_pkg::ildp_item_t  push_item,
  input  wire logic                  pop,
  output ildp_pkg::ildp_item_t       head,
  output ildp_pkg::ildp_qstat_t      qstat
);
  import ildp_pkg::*;

  ildp_item_t          mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_LW-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.level = level_r;
  assign qstat.full  = (level_r == QUEUE_LW'(QUEUE_DEPTH));
  assign qstat.empty = (level_r == '0);

endmodule

`default_nettype wire

// ===== design/ildp_back.sv =====
// Parser: leader checks, directory decoding, terminator and field-area pass-through.
`default_nettype none

module ildp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ildp_pkg::ildp_item_t  head,
  input  wire logic                  head_valid,
  output logic                       pop,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output ildp_pkg::ildp_result_t     out_result
);
  import ildp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEADER = 3'd1;
  localparam logic [2:0] PH_DIR    = 3'd2;
  localparam logic [2:0] PH_TERM   = 3'd3;
  localparam logic [2:0] PH_AREA   = 3'd4;

  // Leader byte positions.
  localparam logic [4:0] LI_LEN_LO   = 5'd0;
  localparam logic [4:0] LI_LEN_HI   = 5'd4;
  localparam logic [4:0] LI_STAMP_LO = 5'd5;
  localparam logic [4:0] LI_STAMP_HI = 5'd11;
  localparam logic [4:0] LI_OFF_LO   = 5'd12;
  localparam logic [4:0] LI_OFF_HI   = 5'd16;
  localparam logic [4:0] LI_IND_LO   = 5'd17;
  localparam logic [4:0] LI_IND_HI   = 5'd19;
  localparam logic [4:0] LI_LSIZE    = 5'd20;
  localparam logic [4:0] LI_PSIZE    = 5'd21;
  localparam logic [4:0] LI_RESV     = 5'd22;
  localparam logic [4:0] LI_TSIZE    = 5'd23;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_FOUR = 8'h34;

  // Parser state.
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  li_r, li_nxt;
  logic        kind_r, kind_nxt;
  logic [16:0] rl_r, rl_nxt;
  logic [16:0] ao_r, ao_nxt;
  logic [3:0]  ld_r, ld_nxt;
  logic [3:0]  pd_r, pd_nxt;
  logic [16:0] dl_r, dl_nxt;
  logic [4:0]  ei_r, ei_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [29:0] len_r, len_nxt;
  logic [29:0] pos_r, pos_nxt;
  logic [16:0] al_r, al_nxt;

  // State as seen by the current byte, after a possible restart.
  logic [2:0]  cur_phase;
  logic [4:0]  cur_li;
  logic        cur_kind;
  logic [16:0] cur_rl, cur_ao, cur_dl, cur_al;
  logic [3:0]  cur_ld, cur_pd;
  logic [4:0]  cur_ei;
  logic [31:0] cur_tag;
  logic [29:0] cur_len, cur_pos;

  logic [4:0]  esize;
  logic [4:0]  ei_inc;
  logic [2:0]  stamp_idx;
  logic [1:0]  ind_idx;
  logic        size_ok;
  logic        do_fail;
  logic [3:0]  fail_code;
  logic        emit;
  ildp_result_t res;
  logic        lane_upd;

  // Running remainders of the field-area offset, one lane per possible entry size.
  logic [4:0]           rem_r [MOD_LANES];
  logic [MOD_LANES-1:0] dir_match;
  logic [MOD_IW-1:0]    lane_sel;
  logic                 out_valid_r, out_valid_nxt;
  ildp_result_t         res_r;

  for (genvar g = 0; g < MOD_LANES; g++) begin : g_lane
    localparam int unsigned M     = MOD_LO + g;
    localparam int unsigned RECIP = (65536 + M - 1) / M;
    logic [7:0]  v;
    logic [21:0] prod;
    logic [5:0]  q;
    logic [7:0]  rem_new;

    // (rem * 10 + digit) mod M by reciprocal multiplication; exact for 8-bit values.
    always_comb begin
      v       = 8'(rem_r[g]) * 8'd10 + 8'(head.digit);
      prod    = 22'(v) * 22'(RECIP);
      q       = prod[21:16];
      rem_new = v - 8'(q) * 8'(M);
    end

    assign dir_match[g] = (rem_r[g] == 5'(DIR_BASE % M));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rem_r[g] <= '0;
      end else if (pop) begin
        if (head.record_start) begin
          rem_r[g] <= '0;
        end else if (lane_upd) begin
          rem_r[g] <= rem_new[4:0];
        end
      end
    end
  end

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    if (head.record_start) begin
      cur_phase = PH_LEADER;
      cur_li    = '0;
      cur_kind  = head.descriptive_record;
      cur_rl    = '0;
      cur_ao    = '0;
      cur_ld    = '0;
      cur_pd    = '0;
      cur_dl    = '0;
      cur_ei    = '0;
      cur_tag   = '0;
      cur_len   = '0;
      cur_pos   = '0;
      cur_al    = '0;
    end else begin
      cur_phase = phase_r;
      cur_li    = li_r;
      cur_kind  = kind_r;
      cur_rl    = rl_r;
      cur_ao    = ao_r;
      cur_ld    = ld_r;
      cur_pd    = pd_r;
      cur_dl    = dl_r;
      cur_ei    = ei_r;
      cur_tag   = tag_r;
      cur_len   = len_r;
      cur_pos   = pos_r;
      cur_al    = al_r;
    end

    esize     = 5'(TAG_BYTES) + 5'(cur_ld) + 5'(cur_pd);
    ei_inc    = cur_ei + 5'd1;
    stamp_idx = 3'(cur_li - LI_STAMP_LO);
    ind_idx   = 2'(cur_li - LI_IND_LO);
    lane_sel  = MOD_IW'(esize - 5'(MOD_LO));
    size_ok   = head.is_digit && (head.digit != 4'd0) && (head.digit <= 4'(MAX_DIGITS));

    phase_nxt = cur_phase;
    li_nxt    = cur_li;
    kind_nxt  = cur_kind;
    rl_nxt    = cur_rl;
    ao_nxt    = cur_ao;
    ld_nxt    = cur_ld;
    pd_nxt    = cur_pd;
    dl_nxt    = cur_dl;
    ei_nxt    = cur_ei;
    tag_nxt   = cur_tag;
    len_nxt   = cur_len;
    pos_nxt   = cur_pos;
    al_nxt    = cur_al;

    do_fail   = 1'b0;
    fail_code = ERR_STAMP;
    emit      = 1'b0;
    res       = '0;
    lane_upd  = 1'b0;

    case (cur_phase)
      PH_LEADER: begin
        li_nxt = cur_li + 5'd1;
        if (cur_li inside {[LI_LEN_LO:LI_LEN_HI]}) begin
          if (!head.is_digit) begin
            do_fail   = 1'b1;
            fail_code = ERR_DIGIT;
          end else begin
            rl_nxt = (cur_rl << 3) + (cur_rl << 1) + 17'(head.digit);
          end
        end else if (cur_li inside {[LI_STAMP_LO:LI_STAMP_HI]}) begin
          if (head.data_byte != stamp_byte(cur_kind, stamp_idx)) begin
            do_fail   = 1'b1;
            fail_code = ERR_STAMP;
          end
        end else if (cur_li inside {[LI_OFF_LO:LI_OFF_HI]}) begin
          if (!head.is_digit) begin
            do_fail   = 1'b1;
            fail_code = ERR_DIGIT;
          end else begin
            ao_nxt   = (cur_ao << 3) + (cur_ao << 1) + 17'(head.digit);
            lane_upd = 1'b1;
          end
        end else if (cur_li inside {[LI_IND_LO:LI_IND_HI]}) begin
          if (head.data_byte != indicator_byte(cur_kind, ind_idx)) begin
            do_fail   = 1'b1;
            fail_code = ERR_INDICATOR;
          end
        end else if (cur_li == LI_LSIZE) begin
          if (!size_ok) begin
            do_fail   = 1'b1;
            fail_code = ERR_LEN_SIZE;
          end else begin
            ld_nxt = head.digit;
          end
        end else if (cur_li == LI_PSIZE) begin
          if (!size_ok) begin
            do_fail   = 1'b1;
            fail_code = ERR_POS_SIZE;
          end else begin
            pd_nxt = head.digit;
          end
        end else if (cur_li == LI_RESV) begin
          if (head.data_byte != ASCII_ZERO) begin
            do_fail   = 1'b1;
            fail_code = ERR_RESERVED;
          end
        end else if (cur_li == LI_TSIZE) begin
          if (head.data_byte != ASCII_FOUR) begin
            do_fail   = 1'b1;
            fail_code = ERR_TAG_SIZE;
          end else if (cur_ao < 17'(DIR_BASE) + 17'(esize)) begin
            do_fail   = 1'b1;
            fail_code = ERR_DIR_SIZE;
          end else if (!dir_match[lane_sel]) begin
            do_fail   = 1'b1;
            fail_code = ERR_DIR_SIZE;
          end else begin
            dl_nxt    = cur_ao - 17'(DIR_BASE);
            ei_nxt    = '0;
            tag_nxt   = '0;
            len_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = PH_DIR;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end

      PH_DIR: begin
        if (cur_ei < 5'(TAG_BYTES)) begin
          tag_nxt = {cur_tag[23:0], head.data_byte};
        end else if (!head.is_digit) begin
          do_fail   = 1'b1;
          fail_code = ERR_DIGIT;
        end else if (cur_ei < 5'(TAG_BYTES) + 5'(cur_ld)) begin
          len_nxt = (cur_len << 3) + (cur_len << 1) + 30'(head.digit);
        end else begin
          pos_nxt = (cur_pos << 3) + (cur_pos << 1) + 30'(head.digit);
        end
        if (!do_fail) begin
          ei_nxt = ei_inc;
          if (ei_inc >= esize) begin
            emit               = 1'b1;
            res.result_kind    = KIND_ENTRY;
            res.entry_tag      = tag_nxt;
            res.entry_length   = len_nxt;
            res.entry_position = pos_nxt;
            dl_nxt  = (cur_dl > 17'(esize)) ? cur_dl - 17'(esize) : '0;
            ei_nxt  = '0;
            tag_nxt = '0;
            len_nxt = '0;
            pos_nxt = '0;
            if (dl_nxt == '0) begin
              phase_nxt = PH_TERM;
            end
          end
        end
      end

      PH_TERM: begin
        if (head.data_byte != FIELD_END) begin
          do_fail   = 1'b1;
          fail_code = ERR_TERMINATOR;
        end else begin
          al_nxt          = (cur_rl > cur_ao) ? cur_rl - cur_ao : '0;
          emit            = 1'b1;
          res.result_kind = KIND_HEADER;
          if (al_nxt == '0) begin
            phase_nxt      = PH_IDLE;
            res.record_end = 1'b1;
          end else begin
            phase_nxt = PH_AREA;
          end
        end
      end

      PH_AREA: begin
        al_nxt           = (cur_al != '0) ? cur_al - 17'd1 : cur_al;
        emit             = 1'b1;
        res.result_kind  = KIND_BYTE;
        res.payload_byte = head.data_byte;
        if (al_nxt == '0) begin
          phase_nxt      = PH_IDLE;
          res.record_end = 1'b1;
        end
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (do_fail) begin
      phase_nxt       = PH_IDLE;
      emit            = 1'b1;
      res             = '0;
      res.result_kind = KIND_ERROR;
      res.error_code  = fail_code;
      res.record_end  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      li_r    <= '0;
      kind_r  <= 1'b0;
      rl_r    <= '0;
      ao_r    <= '0;
      ld_r    <= '0;
      pd_r    <= '0;
      dl_r    <= '0;
      ei_r    <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      al_r    <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      li_r    <= li_nxt;
      kind_r  <= kind_nxt;
      rl_r    <= rl_nxt;
      ao_r    <= ao_nxt;
      ld_r    <= ld_nxt;
      pd_r    <= pd_nxt;
      dl_r    <= dl_nxt;
      ei_r    <= ei_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      al_r    <= al_nxt;
    end
  end

  // Output register: refilled in the same cycle that its old content is taken.
  always_comb begin
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

// ===== design/iso8211_leader_directory_parser_core.sv =====
// Top level of the ISO 8211 record leader and directory parser.
`default_nettype none

// The block reads an ISO 8211 record one byte per request on the input stream and
// sustains one byte per clock cycle: a byte is taken in every cycle in which the
// four-entry queue behind the classifier has room, and the parser drains that queue
// at one byte per cycle whenever its output register is free or is being emptied in
// the same cycle. A byte is stored in the queue, and its result, if it has one, is
// held in the parser's output register until it is taken. A byte flagged as a
// record start (in_tuser bit 0) restarts parsing and selects the descriptive or the
// data stamp (in_tuser bit 1). The 24-byte leader is checked, the directory size is
// checked against the entry size at the last leader byte using running remainders
// kept while the offset digits arrive, one result is given for every directory
// entry, then the field terminator gives a header-complete result and each
// field-area byte is passed on. An error gives one result with its code and marks
// the end of the record; the block then ignores bytes until the next record start.
// There is no clearing pass after reset: the block takes bytes as soon as reset is
// released.
module iso8211_leader_directory_parser_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [ildp_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] data_byte
  input  wire logic [ildp_pkg::IN_USER_W-1:0]       in_tuser,   // [0] record_start,
                                                                // [1] descriptive_record
  // Result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [ildp_pkg::OUT_DATA_W-1:0]           out_tdata,  // [31:0] entry_tag,
                                                                // [61:32] entry_length,
                                                                // [91:62] entry_position,
                                                                // [95:92] error_code,
                                                                // [103:96] payload_byte
  output logic [ildp_pkg::OUT_USER_W-1:0]           out_tuser,  // [1:0] result_kind
  output logic                                      out_tlast   // record_end
);
  import ildp_pkg::*;

  logic         push;
  ildp_item_t   push_item;
  ildp_item_t   head;
  ildp_qstat_t  qstat;
  logic         pop;
  ildp_result_t out_result;

  // Classifier: decodes the stream request and marks decimal digits.
  ildp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue that lets the input side run on while the result side is stalled.
  ildp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Parser with its output register.
  ildp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_result (out_result)
  );

  assign out_tdata = {out_result.payload_byte, out_result.error_code,
                      out_result.entry_position, out_result.entry_length,
                      out_result.entry_tag};
  assign out_tuser = out_result.result_kind;
  assign out_tlast = out_result.record_end;

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= QUEUE_LW'(QUEUE_DEPTH))
    else $error("queue level beyond its depth");

  // An error always closes the record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERROR) |-> out_tlast)
    else $error("error result without record end");

  // A directory entry is never the last result of a record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ENTRY) |-> !out_tlast)
    else $error("directory entry marked as record end");

  // Only error results carry an error code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_ERROR) |-> (out_tdata[95:92] == '0))
    else $error("error code set on a non-error result");

endmodule

`default_nettype wire
